// ===== rtl/core/ecs_pkg.sv =====
// ----------------------------------------------------------------------------
// ecs_pkg
// Shared constants for the epoch-based counter scheduler: table depth,
// index and counter widths, and the reset value of the priority register.
// ----------------------------------------------------------------------------
package ecs_pkg;

	localparam int SLOTS      = 32;
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int CTR_W      = 8;
	localparam int PRIO_W     = 7;
	localparam int OUT_SLOT_W = 5;

	localparam logic [PRIO_W-1:0] PRIO_RESET = 7'd15;

	localparam logic ACT_TICK   = 1'b0;
	localparam logic ACT_CREATE = 1'b1;

endpackage

// ===== rtl/core/epoch_counter_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// epoch_counter_scheduler_unit
// Task slot table with ready flags and time-slice counters. Create requests
// allocate slots; tick requests age the running slot and may reschedule.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_valid/in_ready with action and preempt_hold;
// each request yields exactly one result on out_valid/out_ready. The priority
// register is written through cfg_we/cfg_wdata; the user must do so only
// while the block is idle, which the block does not enforce. in_ready is
// high only while the sequencer is idle, so one request is in flight at a
// time. A tick decrements the running slot's counter and, if it reaches
// zero without preempt_hold, a selection scan picks the ready slot with
// the largest counter; a recharge pass and a second scan follow when all
// ready counters are zero. Every pass streams through the counter memory
// one slot per cycle on its single read port and shared comparator. The
// result sits in an output register; a stalled receiver holds it there and
// the next request still enters, finishing only once the register frees.
// Reset clears the ready flags, makes slot 0 the running task with a zero
// counter, sets one used slot and loads the priority register with 15.
// ----------------------------------------------------------------------------
module epoch_counter_scheduler_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            action,
	input  logic                            preempt_hold,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ecs_pkg::OUT_SLOT_W-1:0] running_slot,
	output logic                            switched,
	output logic [ecs_pkg::OUT_SLOT_W-1:0] new_slot,
	output logic                            table_full,
	input  logic                            cfg_we,
	input  logic [ecs_pkg::PRIO_W-1:0]     cfg_wdata
);
	import ecs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_SCAN,
		ST_RECH,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [CTR_W-1:0]    ctr_mem [SLOTS];
	logic [CTR_W-1:0]    mem_rd_q;
	logic                mem_we;
	logic [SLOT_W-1:0]   mem_wa;
	logic [CTR_W-1:0]    mem_wd;
	logic [SLOT_W-1:0]   mem_ra;

	logic [SLOTS-1:0]    ready_q;
	logic                zero_ok_q;
	logic [SLOT_W-1:0]   run_q;
	logic [CNT_W-1:0]    used_q;
	logic [PRIO_W-1:0]   prio_q;
	logic                hold_q;
	logic [CNT_W-1:0]    ia_q;
	logic                dv_q;
	logic [SLOT_W-1:0]   rd_idx_q;
	logic                found_q;
	logic [CTR_W-1:0]    best_q;
	logic [SLOT_W-1:0]   sel_q;
	logic                recharged_q;

	logic [SLOT_W-1:0]   res_run_q;
	logic                res_sw_q;
	logic [SLOT_W-1:0]   res_new_q;
	logic                res_full_q;

	logic                out_valid_q;
	logic [OUT_SLOT_W-1:0] running_slot_q;
	logic                switched_q;
	logic [OUT_SLOT_W-1:0] new_slot_q;
	logic                table_full_q;

	logic [CTR_W-1:0]    rd_val;
	logic [CTR_W-1:0]    dec_val;
	logic [CTR_W:0]      rech_sum;
	logic [CTR_W-1:0]    rech_val;
	logic                issue;
	logic                pass_done;
	logic                has_free;
	logic                better;
	logic [SLOT_W-1:0]   next_run;

	assign rd_val    = (rd_idx_q == '0 && !zero_ok_q) ? '0 : mem_rd_q;
	assign dec_val   = (rd_val == '0) ? '0 : rd_val - CTR_W'(1);
	assign rech_sum  = (CTR_W+1)'(rd_val >> 1) + (CTR_W+1)'(prio_q);
	assign rech_val  = rech_sum[CTR_W] ? '1 : rech_sum[CTR_W-1:0];
	assign issue     = (ia_q < used_q);
	assign pass_done = (ia_q == used_q) && !dv_q;
	assign has_free  = (used_q < CNT_W'(SLOTS));
	assign better    = dv_q && ready_q[rd_idx_q] && (!found_q || rd_val > best_q);
	assign next_run  = found_q ? sel_q : '0;
	assign mem_ra    = (state_q == ST_IDLE) ? run_q : ia_q[SLOT_W-1:0];

	always_comb begin
		mem_we = 1'b0;
		mem_wa = rd_idx_q;
		mem_wd = rech_val;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && action == ACT_CREATE && has_free) begin
					mem_we = 1'b1;
					mem_wa = used_q[SLOT_W-1:0];
					mem_wd = '0;
				end
			end
			ST_TICK: begin
				mem_we = 1'b1;
				mem_wa = run_q;
				mem_wd = dec_val;
			end
			ST_RECH: begin
				mem_we = dv_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ctr_mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= ctr_mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_q <= PRIO_RESET;
		end else if (cfg_we) begin
			prio_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ready_q        <= '0;
			zero_ok_q      <= 1'b0;
			run_q          <= '0;
			used_q         <= CNT_W'(1);
			hold_q         <= 1'b0;
			ia_q           <= '0;
			dv_q           <= 1'b0;
			rd_idx_q       <= '0;
			found_q        <= 1'b0;
			best_q         <= '0;
			sel_q          <= '0;
			recharged_q    <= 1'b0;
			res_run_q      <= '0;
			res_sw_q       <= 1'b0;
			res_new_q      <= '0;
			res_full_q     <= 1'b0;
			out_valid_q    <= 1'b0;
			running_slot_q <= '0;
			switched_q     <= 1'b0;
			new_slot_q     <= '0;
			table_full_q   <= 1'b0;
		end else begin
			rd_idx_q <= mem_ra;
			if (mem_we && mem_wa == '0) begin
				zero_ok_q <= 1'b1;
			end
			if (out_valid_q && out_ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					dv_q <= 1'b0;
					if (in_valid) begin
						hold_q   <= preempt_hold;
						res_run_q <= run_q;
						res_sw_q  <= 1'b0;
						res_new_q <= (action == ACT_CREATE && has_free) ?
							used_q[SLOT_W-1:0] : '0;
						res_full_q <= (action == ACT_CREATE && !has_free);
						if (action == ACT_CREATE) begin
							if (has_free) begin
								ready_q[used_q[SLOT_W-1:0]] <= 1'b1;
								used_q    <= used_q + CNT_W'(1);
							end
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_TICK;
						end
					end
				end
				ST_TICK: begin
					if (dec_val == '0 && !hold_q) begin
						ia_q        <= '0;
						dv_q        <= 1'b0;
						found_q     <= 1'b0;
						best_q      <= '0;
						sel_q       <= '0;
						recharged_q <= 1'b0;
						state_q     <= ST_SCAN;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_SCAN: begin
					dv_q <= issue;
					if (issue) begin
						ia_q <= ia_q + CNT_W'(1);
					end
					if (better) begin
						found_q <= 1'b1;
						best_q  <= rd_val;
						sel_q   <= rd_idx_q;
					end
					if (pass_done) begin
						if (found_q && best_q == '0 && !recharged_q) begin
							recharged_q <= 1'b1;
							ia_q        <= '0;
							state_q     <= ST_RECH;
						end else begin
							run_q     <= next_run;
							res_run_q <= next_run;
							res_sw_q  <= (next_run != run_q);
							state_q   <= ST_OUT;
						end
					end
				end
				ST_RECH: begin
					dv_q <= issue;
					if (issue) begin
						ia_q <= ia_q + CNT_W'(1);
					end
					if (pass_done) begin
						ia_q    <= '0;
						found_q <= 1'b0;
						best_q  <= '0;
						sel_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_OUT: begin
					dv_q <= 1'b0;
					if (!out_valid_q || out_ready) begin
						out_valid_q    <= 1'b1;
						running_slot_q <= OUT_SLOT_W'(res_run_q);
						switched_q     <= res_sw_q;
						new_slot_q     <= OUT_SLOT_W'(res_new_q);
						table_full_q   <= res_full_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign running_slot = running_slot_q;
	assign switched     = switched_q;
	assign new_slot     = new_slot_q;
	assign table_full   = table_full_q;

endmodule
